// ----- hw/rtl/tsf_pkg.sv -----
// ---------------------------------------------------------------------------
// tsf_pkg: shared definitions for the timestamped transmit sample framer
// Word kinds, input format codes, register indexes and default sizes.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package tsf_pkg;

    // Default sizes
    localparam int MAX_SLOTS_DEF    = 65536;
    localparam int HEADER_SLOTS_DEF = 2;
    localparam int SLOTS_MIN        = 3;
    localparam int SLOTS_RESET      = 4096;

    // Output word kinds
    localparam logic [1:0] KIND_SAMPLE   = 2'd0;
    localparam logic [1:0] KIND_TS_LOW   = 2'd1;
    localparam logic [1:0] KIND_TS_HIGH  = 2'd2;
    localparam logic [1:0] KIND_ZERO_RUN = 2'd3;

    // Input sample formats (unused code falls back to CS16)
    localparam logic [1:0] FMT_CS16 = 2'd0;
    localparam logic [1:0] FMT_CS12 = 2'd1;
    localparam logic [1:0] FMT_CS8  = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_SAMPLE_FORMAT    = 2'd0;
    localparam logic [1:0] CFG_TIMESTAMP_ENABLE = 2'd1;
    localparam logic [1:0] CFG_BUFFER_SLOTS     = 2'd2;

    // Result words one input can produce
    localparam int RB_DEPTH = 4;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] data;
        logic        last;
        logic        back;
    } word_t;

    typedef struct packed {
        logic [31:0] sample;
        logic        has_time;
        logic [63:0] stime;
        logic        end_burst;
    } in_t;

endpackage

// ----- hw/rtl/timestamped_tx_sample_framer.sv -----
// ---------------------------------------------------------------------------
// timestamped_tx_sample_framer: top level of the transmit sample framer
// Converts samples, frames them into buffers with timestamp headers and
// zero-run skips, and emits up to four words per input sample.
// ---------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+--------------------------------------------
//  in      | in_valid / in_ready  | packed_sample, has_time, sample_time,
//          |                      | end_burst
//  out     | out_valid/out_ready  | word_kind, word_data, buffer_last,
//          |                      | time_went_back
//  cfg     | cfg_valid/cfg_ready  | cfg_index, cfg_data (cfg_ready always high)
//
//  A sample is captured in an input register, then one pass of logic updates
//  the framing state and loads its 1 to 4 words into a result buffer.
//  The result buffer drains one word per cycle while out_ready is high; a
//  new sample is taken in the cycle its last word leaves, so plain samples
//  flow at one per cycle without stalls; extra words hold off the next sample.
//  Reset clears the framing state, the registers and both buffer stages.
//  A stall on out holds the current word and fills back through in_ready.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module timestamped_tx_sample_framer #(
    parameter int MAX_BUFFER_SLOTS = tsf_pkg::MAX_SLOTS_DEF,
    parameter int HEADER_SLOTS     = tsf_pkg::HEADER_SLOTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // sample input
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] packed_sample,
    input  logic        has_time,
    input  logic [63:0] sample_time,
    input  logic        end_burst,
    // word output
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  word_kind,
    output logic [31:0] word_data,
    output logic        buffer_last,
    output logic        time_went_back,
    // configuration
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [16:0] cfg_data
);
    import tsf_pkg::*;

    localparam int SLOT_W = $clog2(MAX_BUFFER_SLOTS + 1);
    localparam int CMP_W  = (SLOT_W > 17) ? SLOT_W : 17;
    localparam int SLOTS_DEF = (SLOTS_RESET > MAX_BUFFER_SLOTS) ?
                               MAX_BUFFER_SLOTS : SLOTS_RESET;

    // Configuration
    logic [1:0]        fmt_reg;
    logic              ts_en_reg;
    logic [SLOT_W-1:0] slots_reg;
    logic [CMP_W-1:0]  bs_ext;
    logic [SLOT_W-1:0] slots_next;

    // Input stage
    logic  s1_valid_reg;
    in_t   s1_reg;
    logic  load;
    logic  rb_free;

    // Framing state
    logic              open_reg;
    logic [SLOT_W-1:0] filled_reg;
    logic [63:0]       rt_reg;
    logic              open_next;
    logic [SLOT_W-1:0] filled_next;
    logic [63:0]       rt_next;

    // Result buffer
    word_t             rb_reg [RB_DEPTH];
    logic [1:0]        rb_idx_reg;
    logic [2:0]        rb_left_reg;
    word_t             w_next [RB_DEPTH];
    logic [2:0]        cnt_next;
    word_t             cur;

    // Step datapath
    logic [31:0]       iq;
    logic              ovf;
    logic              open1;
    logic              skip_on;
    logic [63:0]       gap;
    logic [SLOT_W-1:0] room;
    logic              gap_lt;
    logic [SLOT_W-1:0] fill;
    logic              skip_close;
    logic              open2;
    logic              hdr;
    logic [63:0]       rt_room;
    logic              back;
    logic [SLOT_W-1:0] filled_pre;
    logic [SLOT_W-1:0] filled_post;
    logic              last;

    // Configuration port: always ready, clamp slot count on write
    assign cfg_ready = 1'b1;
    assign bs_ext    = CMP_W'(cfg_data);

    always_comb
    begin
        if (bs_ext < CMP_W'(SLOTS_MIN))
            slots_next = SLOT_W'(SLOTS_MIN);
        else if (bs_ext > CMP_W'(MAX_BUFFER_SLOTS))
            slots_next = SLOT_W'(MAX_BUFFER_SLOTS);
        else
            slots_next = bs_ext[SLOT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg   <= FMT_CS16;
            ts_en_reg <= 1'b0;
            slots_reg <= SLOT_W'(SLOTS_DEF);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_SAMPLE_FORMAT:    fmt_reg   <= cfg_data[1:0];
                CFG_TIMESTAMP_ENABLE: ts_en_reg <= cfg_data[0];
                CFG_BUFFER_SLOTS:     slots_reg <= slots_next;
                default:              ;
            endcase
        end
    end

    // Handshake between the stages
    assign rb_free  = (rb_left_reg == 3'd0) || (rb_left_reg == 3'd1 && out_ready);
    assign load     = s1_valid_reg && rb_free;
    assign in_ready = !s1_valid_reg || rb_free;

    // Capture the input word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ready)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_reg.sample    <= packed_sample;
            s1_reg.has_time  <= has_time;
            s1_reg.stime     <= sample_time;
            s1_reg.end_burst <= end_burst;
        end
    end

    tsf_convert u_convert (
        .sample_format (fmt_reg),
        .raw           (s1_reg.sample),
        .iq            (iq)
    );

    // Close an overfilled buffer, then work out the skip
    assign ovf     = open_reg && (filled_reg >= slots_reg);
    assign open1   = open_reg && !ovf;
    assign skip_on = open1 && ts_en_reg && s1_reg.has_time;
    assign gap     = s1_reg.stime - rt_reg;
    assign room    = slots_reg - filled_reg;
    assign gap_lt  = (gap[63:SLOT_W] == '0) && (gap[SLOT_W-1:0] < room);
    assign fill    = gap_lt ? gap[SLOT_W-1:0] : room;

    // Skip up to the free space closes the buffer
    assign skip_close = skip_on && !gap_lt;
    assign open2      = open1 && !skip_close;
    assign hdr        = !open2 && ts_en_reg;

    // Time comparison against the running count after any skip
    assign rt_room = rt_reg + 64'(room);
    assign back    = skip_close ? (s1_reg.stime < rt_room) : (s1_reg.stime < rt_reg);

    // Slot count and running ticks after the sample
    always_comb
    begin
        if (open2)
            filled_pre = skip_on ? (filled_reg + fill) : filled_reg;
        else if (ts_en_reg)
            filled_pre = SLOT_W'(HEADER_SLOTS);
        else
            filled_pre = '0;
    end

    assign filled_post = filled_pre + SLOT_W'(1);
    assign last        = (filled_post >= slots_reg) || s1_reg.end_burst;
    assign open_next   = !last;
    assign filled_next = filled_post;
    // a header, or a skip that lands on time, puts the count at the sample time
    assign rt_next     = (hdr || (skip_on && gap_lt)) ? (s1_reg.stime + 64'd1)
                                                      : (rt_reg + 64'd1);

    // Assemble the words of this sample in order
    always_comb
    begin
        for (int k = 0; k < RB_DEPTH; k++)
            w_next[k] = '0;
        cnt_next = 3'd0;
        if (ovf)
        begin
            w_next[cnt_next[1:0]] = '{kind: KIND_ZERO_RUN, data: 32'd0,
                                      last: 1'b1, back: 1'b0};
            cnt_next = cnt_next + 3'd1;
        end
        if (skip_on && (fill != '0))
        begin
            w_next[cnt_next[1:0]] = '{kind: KIND_ZERO_RUN, data: 32'(fill),
                                      last: skip_close, back: 1'b0};
            cnt_next = cnt_next + 3'd1;
        end
        if (hdr)
        begin
            w_next[cnt_next[1:0]] = '{kind: KIND_TS_LOW, data: s1_reg.stime[31:0],
                                      last: 1'b0, back: back};
            cnt_next = cnt_next + 3'd1;
            w_next[cnt_next[1:0]] = '{kind: KIND_TS_HIGH, data: s1_reg.stime[63:32],
                                      last: 1'b0, back: back};
            cnt_next = cnt_next + 3'd1;
        end
        w_next[cnt_next[1:0]] = '{kind: KIND_SAMPLE, data: iq,
                                  last: last, back: 1'b0};
        cnt_next = cnt_next + 3'd1;
    end

    // Advance framing state on each processed sample
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg   <= 1'b0;
            filled_reg <= '0;
            rt_reg     <= '0;
        end
        else if (load)
        begin
            open_reg   <= open_next;
            filled_reg <= filled_next;
            rt_reg     <= rt_next;
        end
    end

    // Result buffer: load a full set, drain one word per cycle while out_ready is high
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rb_idx_reg  <= '0;
            rb_left_reg <= '0;
        end
        else if (load)
        begin
            rb_idx_reg  <= '0;
            rb_left_reg <= cnt_next;
        end
        else if (out_valid && out_ready)
        begin
            rb_idx_reg  <= rb_idx_reg + 2'd1;
            rb_left_reg <= rb_left_reg - 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int k = 0; k < RB_DEPTH; k++)
                rb_reg[k] <= w_next[k];
        end
    end

    // Present the current word
    assign cur            = rb_reg[rb_idx_reg];
    assign out_valid      = (rb_left_reg != 3'd0);
    assign word_kind      = cur.kind;
    assign word_data      = cur.data;
    assign buffer_last    = cur.last;
    assign time_went_back = cur.back;

endmodule

// ----- hw/rtl/tsf_convert.sv -----
// ---------------------------------------------------------------------------
// tsf_convert: sample format converter
// Turns a CS16, packed CS12 or CS8 sample into MSB-aligned 16-bit I and Q.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tsf_convert (
    input  logic [1:0]  sample_format,
    input  logic [31:0] raw,
    output logic [31:0] iq
);
    import tsf_pkg::*;

    logic [7:0]  b0;
    logic [7:0]  b1;
    logic [7:0]  b2;
    logic [15:0] i_val;
    logic [15:0] q_val;

    assign b0 = raw[7:0];
    assign b1 = raw[15:8];
    assign b2 = raw[23:16];

    // Pick the unpacking for the active format
    always_comb
    begin
        case (sample_format)
            FMT_CS12:
            begin
                i_val = {b1[3:0], b0, 4'h0};
                q_val = {b2, b1[7:4], 4'h0};
            end
            FMT_CS8:
            begin
                i_val = {b0, 8'h00};
                q_val = {b1, 8'h00};
            end
            default:
            begin
                i_val = raw[15:0];
                q_val = raw[31:16];
            end
        endcase
    end

    assign iq = {q_val, i_val};

endmodule

// ----- hw/rtl/tsf_checker.sv -----
// ---------------------------------------------------------------------------
// tsf_checker: port-level checks for the sample framer
// Watches the output channel for framing rules and stall behavior.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tsf_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  word_kind,
    input logic [31:0] word_data,
    input logic        buffer_last,
    input logic        time_went_back
);
    import tsf_pkg::*;

    // Hold a stalled word
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(word_kind)
            && $stable(word_data) && $stable(buffer_last))
        else $error("output word changed while stalled");

    // Low timestamp half is followed at once by the high half
    a_ts_pair: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && word_kind == KIND_TS_LOW
            |=> out_valid && word_kind == KIND_TS_HIGH)
        else $error("timestamp high half missing after low half");

    // Header words never close a buffer
    a_hdr_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (word_kind == KIND_TS_LOW || word_kind == KIND_TS_HIGH)
            |-> !buffer_last)
        else $error("timestamp word marked last");

    // Time-went-back flag only on header words
    a_back_hdr: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && time_went_back
            |-> (word_kind == KIND_TS_LOW || word_kind == KIND_TS_HIGH))
        else $error("time_went_back on a non-header word");

endmodule

bind timestamped_tx_sample_framer tsf_checker u_tsf_checker (.*);
